FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define BRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define BRD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/brd_pkg.sv
// Shared types, constants and helpers for the BMP run-length decoder.
`timescale 1ns / 1ps

package brd_pkg;

    // Largest image dimensions the decoder supports.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Field widths.
    localparam int CFG_W = 13;
    localparam int COL_W = 13;
    localparam int ROW_W = 14;
    localparam int IDX_W = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FOUR_BIT_MODE = 2'd2;

    // Decoder phases, one-hot.
    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_SECOND = 7'b0000010,
        PH_ABS    = 7'b0000100,
        PH_PAD    = 7'b0001000,
        PH_DX     = 7'b0010000,
        PH_DY     = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             four_bit;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  count;
        logic [7:0]  pixel;
        logic        done;
    } seg_t;

    // Clamps a configured dimension to the supported maximum.
    function automatic logic [CFG_W-1:0] clip_dim(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

FILE: rtl/core/bmp_rle_decoder_top.sv
// A result enters the output register, or the skid entry, and is offered on the m_ channel from there.
// Throughput: one stream byte per cycle while s_ready is high; each byte yields at most one result.
// An output register plus one skid entry keep s_ready high while a result waits.
// Reset (aresetn low, synchronous) empties the buffer and sets width 1, height 1, RLE8.
// Top level of the BMP RLE8/RLE4 decoder.
`timescale 1ns / 1ps

module bmp_rle_decoder_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [brd_pkg::IDX_W-1:0] cfg_index,
    input  logic [brd_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_stream_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [11:0]               m_seg_column,
    output logic [11:0]               m_seg_row,
    output logic [7:0]                m_seg_count,
    output logic [7:0]                m_pixel_byte,
    output logic                      m_image_done
);
    import brd_pkg::*;

    cfg_t cfg_q;
    cfg_t cfg_d;
    logic restart;
    logic in_fire;
    logic res_valid;
    seg_t res_seg;
    seg_t m_seg;

    assign in_fire = s_valid && s_ready;

    // Configuration registers.
    brd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg_q       (cfg_q),
        .cfg_d       (cfg_d),
        .restart     (restart)
    );

    // Record decoding.
    brd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_stream_byte),
        .cfg_q     (cfg_q),
        .cfg_d     (cfg_d),
        .restart   (restart),
        .res_valid (res_valid),
        .res_seg   (res_seg)
    );

    // Result buffering.
    brd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_valid),
        .push_seg (res_seg),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_seg    (m_seg)
    );

    assign m_seg_column = m_seg.column;
    assign m_seg_row    = m_seg.row;
    assign m_seg_count  = m_seg.count;
    assign m_pixel_byte = m_seg.pixel;
    assign m_image_done = m_seg.done;

endmodule

FILE: rtl/core/brd_cfg.sv
// Configuration registers of the decoder and the restart request on a write.
`timescale 1ns / 1ps

module brd_cfg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [brd_pkg::IDX_W-1:0] cfg_index,
    input  logic [brd_pkg::CFG_W-1:0] cfg_wr_data,
    output brd_pkg::cfg_t            cfg_q,
    output brd_pkg::cfg_t            cfg_d,
    output logic                     restart
);
    import brd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; any valid register index restarts decoding.
    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    cfg_next.width = cfg_wr_data;
                    restart        = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    cfg_next.height = cfg_wr_data;
                    restart         = 1'b1;
                end
                REG_FOUR_BIT_MODE: begin
                    cfg_next.four_bit = cfg_wr_data[0];
                    restart           = 1'b1;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Register set with its reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width    <= CFG_W'(1);
            cfg_reg.height   <= CFG_W'(1);
            cfg_reg.four_bit <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_q = cfg_reg;
    assign cfg_d = cfg_next;

endmodule

FILE: rtl/core/brd_core.sv
// Record parser and segment builder: one stream byte per transfer.
`timescale 1ns / 1ps

module brd_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  brd_pkg::cfg_t cfg_q,
    input  brd_pkg::cfg_t cfg_d,
    input  logic          restart,
    output logic          res_valid,
    output brd_pkg::seg_t res_seg
);
    import brd_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              first_byte_reg, first_byte_next;
    logic [COL_W-1:0]        column_reg, column_next;
    logic signed [ROW_W-1:0] row_reg, row_next;
    logic [7:0]              abs_rem_reg, abs_rem_next;
    logic                    abs_par_reg, abs_par_next;

    logic [CFG_W-1:0]        width_eff;
    logic signed [ROW_W-1:0] row_init;
    logic [7:0]              take;
    logic [7:0]              abs_rem_dec;
    logic [7:0]              seg_want;
    logic signed [ROW_W-1:0] avail;
    logic                    seg_fits;
    logic [7:0]              seg_cnt;
    logic [COL_W-1:0]        col_adv;
    logic [COL_W-1:0]        col_delta;
    logic signed [ROW_W-1:0] row_delta;
    logic signed [ROW_W-1:0] row_eol;
    logic                    emit_seg;
    logic                    emit_done;

    // Effective dimensions and the starting row after a restart.
    assign width_eff = clip_dim(cfg_q.width, CFG_W'(MAX_WIDTH));
    assign row_init  = $signed({1'b0, clip_dim(cfg_d.height, CFG_W'(MAX_HEIGHT))})
                       - ROW_W'(1);

    // Pixels carried by one absolute-mode byte.
    always_comb begin
        if (cfg_q.four_bit) begin
            take = (abs_rem_reg < 8'd2) ? abs_rem_reg : 8'd2;
        end else begin
            take = (abs_rem_reg < 8'd1) ? abs_rem_reg : 8'd1;
        end
    end
    assign abs_rem_dec = abs_rem_reg - take;

    // Segment clipping against the row width.
    assign seg_want = (phase_reg == PH_ABS) ? take : first_byte_reg;
    assign avail    = $signed({1'b0, width_eff}) - $signed({1'b0, column_reg});
    assign seg_fits = (avail > ROW_W'(0)) && (seg_want != 8'd0);
    assign seg_cnt  = ($signed({6'b0, seg_want}) < avail) ? seg_want : avail[7:0];
    assign col_adv  = column_reg + {5'b0, seg_cnt};

    // Position moves of delta and end-of-line records.
    assign col_delta = column_reg + {5'b0, first_byte_reg};
    assign row_delta = row_reg - $signed({6'b0, in_byte});
    assign row_eol   = row_reg - ROW_W'(1);

    // Next state and result for the byte now on the input.
    always_comb begin
        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        abs_rem_next    = abs_rem_reg;
        abs_par_next    = abs_par_reg;
        emit_seg        = 1'b0;
        emit_done       = 1'b0;
        case (phase_reg)
            PH_FIRST: begin
                first_byte_next = in_byte;
                phase_next      = PH_SECOND;
            end
            PH_SECOND: begin
                phase_next = PH_FIRST;
                if (first_byte_reg != 8'd0) begin
                    // Encoded run.
                    if (seg_fits) begin
                        emit_seg    = 1'b1;
                        column_next = col_adv;
                    end
                end else begin
                    case (in_byte)
                        8'd0: begin
                            // End of line.
                            column_next = '0;
                            row_next    = row_eol;
                            if (row_eol < 0) begin
                                emit_done  = 1'b1;
                                phase_next = PH_DONE;
                            end
                        end
                        8'd1: begin
                            // End of bitmap.
                            emit_done  = 1'b1;
                            phase_next = PH_DONE;
                        end
                        8'd2: begin
                            phase_next = PH_DX;
                        end
                        default: begin
                            // Absolute run header.
                            abs_rem_next = in_byte;
                            abs_par_next = 1'b0;
                            phase_next   = PH_ABS;
                        end
                    endcase
                end
            end
            PH_ABS: begin
                abs_rem_next = abs_rem_dec;
                abs_par_next = ~abs_par_reg;
                if (abs_rem_dec == 8'd0) begin
                    phase_next = abs_par_next ? PH_PAD : PH_FIRST;
                end
                if (seg_fits) begin
                    emit_seg    = 1'b1;
                    column_next = col_adv;
                end
            end
            PH_PAD: begin
                phase_next = PH_FIRST;
            end
            PH_DX: begin
                first_byte_next = in_byte;
                phase_next      = PH_DY;
            end
            PH_DY: begin
                column_next = col_delta;
                row_next    = row_delta;
                phase_next  = PH_FIRST;
                if ((row_delta < 0) || (col_delta > width_eff)) begin
                    emit_done  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    // Decoder state; a configuration write restarts it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIRST;
            first_byte_reg <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            abs_rem_reg    <= '0;
            abs_par_reg    <= 1'b0;
        end else if (restart) begin
            phase_reg      <= PH_FIRST;
            first_byte_reg <= '0;
            column_reg     <= '0;
            row_reg        <= row_init;
            abs_rem_reg    <= '0;
            abs_par_reg    <= 1'b0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            first_byte_reg <= first_byte_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            abs_rem_reg    <= abs_rem_next;
            abs_par_reg    <= abs_par_next;
        end
    end

    // Result item for this byte.
    always_comb begin
        res_valid = in_fire && (emit_seg || emit_done);
        if (emit_done) begin
            res_seg = '{column: '0, row: '0, count: '0, pixel: '0, done: 1'b1};
        end else begin
            res_seg = '{column: column_reg[11:0], row: row_reg[11:0], count: seg_cnt,
                        pixel: in_byte, done: 1'b0};
        end
    end

endmodule

FILE: rtl/core/brd_out_buf.sv
// Output register with one skid entry between the decoder and the result channel.
`timescale 1ns / 1ps

module brd_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  brd_pkg::seg_t push_seg,
    output logic          in_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output brd_pkg::seg_t m_seg
);
    import brd_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    seg_t out_seg_reg, out_seg_next;
    seg_t skid_seg_reg, skid_seg_next;
    logic pop;

    assign pop      = out_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;

    // A new result goes to the output register when it frees up, else to the skid entry.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_seg_next    = out_seg_reg;
        skid_seg_next   = skid_seg_reg;
        if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_seg_next   = push_seg;
            end else begin
                skid_valid_next = 1'b1;
                skid_seg_next   = push_seg;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_seg_next    = skid_seg_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Valid flags are cleared by reset; payload needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_seg_reg  <= out_seg_next;
        skid_seg_reg <= skid_seg_next;
    end

    assign m_valid = out_valid_reg;
    assign m_seg   = out_seg_reg;

endmodule

FILE: rtl/core/brd_checker.sv
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_seg_column,
    input logic [11:0] m_seg_row,
    input logic [7:0]  m_seg_count,
    input logic        m_image_done
);

    logic stalled;
    logic marker_out;
    logic marker_clear;
    logic seg_out;

    // Conditions observed on the result channel.
    assign stalled      = m_valid && !m_ready;
    assign marker_out   = m_valid && m_image_done;
    assign marker_clear = (m_seg_count == 8'd0) && (m_seg_column == 12'd0)
                          && (m_seg_row == 12'd0);
    assign seg_out      = m_valid && !m_image_done;

    // A stalled result stays offered, with its count and done flag unchanged.
    `BRD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, stalled, m_valid)
    `BRD_ASSERT_NEXT(a_hold_data, aclk, aresetn, stalled, $stable(m_seg_count) && $stable(m_image_done))

    // The end marker carries no position and no pixels.
    `BRD_ASSERT_IMPL(a_marker_empty, aclk, aresetn, marker_out, marker_clear)

    // A segment always holds at least one pixel.
    `BRD_ASSERT_IMPL(a_seg_nonempty, aclk, aresetn, seg_out, m_seg_count != 8'd0)

    // Reset leaves the buffer empty and the input open.
    `BRD_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind bmp_rle_decoder_top brd_checker u_brd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_seg_column (m_seg_column),
    .m_seg_row    (m_seg_row),
    .m_seg_count  (m_seg_count),
    .m_image_done (m_image_done)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the BMP RLE8/RLE4 run decoder: directed records, then random images.
`timescale 1ns / 1ps

module tb_top;
    import brd_pkg::*;

    // Cycles without any transfer before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    // Live stream bytes in the random part.
    localparam int RANDOM_BYTES = 700;

    // Predicts the segments of the decoder and checks the ones it delivers.
    class seg_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic             four_bit;

        phase_t phase;
        int     first_b;
        int     col;
        int     row;
        int     abs_left;
        bit     abs_odd;

        seg_t expected_segs[$];
        int   n_live;
        int   n_checked;
        int   n_markers;
        int   n_rle4;
        int   n_errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            four_bit   = 1'b0;
            n_live     = 0;
            n_checked  = 0;
            n_markers  = 0;
            n_rle4     = 0;
            n_errors   = 0;
            restart();
        endfunction

        function int eff_width();
            return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        endfunction

        function int eff_height();
            return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        endfunction

        // Decoding starts again from the top row of the image.
        function void restart();
            phase    = PH_FIRST;
            first_b  = 0;
            col      = 0;
            row      = eff_height() - 1;
            abs_left = 0;
            abs_odd  = 1'b0;
        endfunction

        // A write to any of the three registers also restarts decoding.
        function void write_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH:   width_reg  = val;
                REG_IMAGE_HEIGHT:  height_reg = val;
                REG_FOUR_BIT_MODE: four_bit   = val[0];
                default:           return;
            endcase
            restart();
        endfunction

        function void push_seg(int c, int r, int cnt, int pix, bit done);
            seg_t s;
            s.column = 12'(c);
            s.row    = 12'(r);
            s.count  = 8'(cnt);
            s.pixel  = 8'(pix);
            s.done   = done;
            expected_segs.push_back(s);
            if (four_bit && !done) n_rle4++;
        endfunction

        function void finish_image();
            phase = PH_DONE;
            push_seg(0, 0, 0, 0, 1'b1);
        endfunction

        // Decoding ends once the position leaves the image.
        function void check_stop();
            if (row < 0 || col > eff_width()) finish_image();
        endfunction

        // A run is clipped at the right edge; a run clipped to nothing gives no segment.
        function void emit_run(int want, int pix);
            int avail;
            int cnt;
            avail = eff_width() - col;
            if (avail <= 0) return;
            cnt = (want < avail) ? want : avail;
            if (cnt == 0) return;
            push_seg(col, row, cnt, pix, 1'b0);
            col += cnt;
        endfunction

        // Advances the decoder by one accepted stream byte.
        function void note_input(logic [7:0] b);
            int bv;
            int per_byte;
            int take;
            bv = int'(b);
            if (phase != PH_DONE) n_live++;
            case (phase)
                PH_FIRST: begin
                    first_b = bv;
                    phase   = PH_SECOND;
                end
                PH_SECOND: begin
                    phase = PH_FIRST;
                    if (first_b != 0) begin
                        emit_run(first_b, bv);
                    end else if (bv == 0) begin
                        col = 0;
                        row -= 1;
                        check_stop();
                    end else if (bv == 1) begin
                        finish_image();
                    end else if (bv == 2) begin
                        phase = PH_DX;
                    end else begin
                        abs_left = bv;
                        abs_odd  = 1'b0;
                        phase    = PH_ABS;
                    end
                end
                PH_ABS: begin
                    per_byte = four_bit ? 2 : 1;
                    take     = (abs_left < per_byte) ? abs_left : per_byte;
                    abs_left -= take;
                    abs_odd  = ~abs_odd;
                    if (abs_left == 0) phase = abs_odd ? PH_PAD : PH_FIRST;
                    emit_run(take, bv);
                end
                PH_PAD: phase = PH_FIRST;
                PH_DX: begin
                    first_b = bv;
                    phase   = PH_DY;
                end
                PH_DY: begin
                    col += first_b;
                    row -= bv;
                    phase = PH_FIRST;
                    check_stop();
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            n_errors++;
            if (n_errors <= 10) $display("ERROR: %s", msg);
        endfunction

        // Compares a delivered segment with the oldest one predicted.
        function void check_result(seg_t got);
            seg_t exp_seg;
            if (expected_segs.size() == 0) begin
                report($sformatf("unexpected segment col %0d row %0d cnt %0d pix %02h done %0b",
                                 got.column, got.row, got.count, got.pixel, got.done));
                return;
            end
            exp_seg = expected_segs.pop_front();
            n_checked++;
            if (exp_seg.done) n_markers++;
            if (got.column !== exp_seg.column || got.row !== exp_seg.row ||
                got.count !== exp_seg.count || got.pixel !== exp_seg.pixel ||
                got.done !== exp_seg.done) begin
                report($sformatf({"segment %0d: expected col %0d row %0d cnt %0d pix %02h ",
                                  "done %0b, got col %0d row %0d cnt %0d pix %02h done %0b"},
                                 n_checked, exp_seg.column, exp_seg.row, exp_seg.count,
                                 exp_seg.pixel, exp_seg.done, got.column, got.row,
                                 got.count, got.pixel, got.done));
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn       = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_wr_data   = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [7:0]       s_stream_byte = 8'h00;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [11:0]      m_seg_column;
    logic [11:0]      m_seg_row;
    logic [7:0]       m_seg_count;
    logic [7:0]       m_pixel_byte;
    logic             m_image_done;

    seg_scoreboard seg_sb;
    bit            idle_en     = 1'b1;
    int            idle_cycles = 0;
    int            n_images    = 0;
    int            rand_start;

    bmp_rle_decoder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_seg_column  (m_seg_column),
        .m_seg_row     (m_seg_row),
        .m_seg_count   (m_seg_count),
        .m_pixel_byte  (m_pixel_byte),
        .m_image_done  (m_image_done)
    );

    // Clock, 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The receiver holds off in about one cycle in ten while idling is enabled.
    always @(posedge aclk) begin
        m_ready <= !(idle_en && ($urandom_range(0, 99) < 10));
    end

    // Observes both channels and counts cycles without a transfer.
    always @(posedge aclk) begin
        seg_t got;
        bit   moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.column = m_seg_column;
                got.row    = m_seg_row;
                got.count  = m_seg_count;
                got.pixel  = m_pixel_byte;
                got.done   = m_image_done;
                seg_sb.check_result(got);
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                seg_sb.note_input(s_stream_byte);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog against a hung handshake.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("** bmp_rle_decoder_top: FAILED **");
        $finish;
    end

    // Offers one stream byte, with an occasional gap before it, until its transfer.
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        seg_sb.write_config(idx, val);
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input logic mode);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_FOUR_BIT_MODE, {{(CFG_W-1){1'b0}}, mode});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every predicted segment has arrived and the pipeline is quiet.
    // The first edge lets the monitor note the last transfer before the queue is read.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (seg_sb.expected_segs.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Sends one record: mostly well formed, sometimes a stray byte.
    task automatic send_record();
        int r;
        int n;
        int nbytes;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
            send_byte(8'(n));
            send_byte(8'($urandom_range(0, 255)));
        end else if (r < 62) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            nbytes = seg_sb.four_bit ? (n + 1) / 2 : n;
            send_byte(8'h00);
            send_byte(8'(n));
            for (int i = 0; i < nbytes; i++) send_byte(8'($urandom_range(0, 255)));
            // The pad byte keeps absolute data to a 16-bit boundary.
            if (nbytes % 2) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 72) begin
            send_byte(8'h00);
            send_byte(8'h00);
        end else if (r < 82) begin
            send_byte(8'h00);
            send_byte(8'h02);
            send_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 8)));
            send_byte(8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 2)));
        end else if (r < 90) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            // Long runs that are likely to reach the right edge.
            send_byte(8'($urandom_range(64, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // One image: a fresh configuration followed by a stream of records.
    task automatic random_image();
        int               r;
        int               n_rec;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        r = $urandom_range(0, 99);
        if (r < 5)       w = 13'd1;
        else if (r < 10) w = 13'd4096;
        else if (r < 12) w = 13'd0;
        else if (r < 15) w = 13'($urandom_range(4097, 8191));
        else             w = 13'($urandom_range(2, 300));
        r = $urandom_range(0, 99);
        if (r < 5)       h = 13'd1;
        else if (r < 10) h = 13'd4096;
        else if (r < 12) h = 13'd0;
        else if (r < 15) h = 13'($urandom_range(4097, 8191));
        else             h = 13'($urandom_range(2, 64));
        load_config(w, h, 1'($urandom_range(0, 1)));
        n_rec = $urandom_range(6, 30);
        for (int i = 0; i < n_rec && seg_sb.phase != PH_DONE; i++) send_record();
        if (seg_sb.phase != PH_DONE && $urandom_range(0, 4) != 0) begin
            send_byte(8'h00);
            send_byte(8'h01);
        end
        // Bytes after the end of the image must be ignored.
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
        settle();
    endtask

    initial begin
        seg_sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: a run clipped to one pixel, then end of line stops decoding.
        send_byte(8'h03);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h55);
        settle();

        // Largest image: full-length run, widest delta, end of bitmap.
        load_config(13'd4096, 13'd4096, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h01);
        settle();

        // RLE4 absolute run with its pad byte, then a run clipped to nothing.
        load_config(13'd5, 13'd3, 1'b1);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h00);
        send_byte(8'h06);
        send_byte(8'hC3);
        settle();

        // Zero width and zero height.
        load_config(13'd0, 13'd0, 1'b0);
        send_byte(8'h04);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // Random images; two of them run without any idling.
        rand_start = seg_sb.n_live;
        while (seg_sb.n_live - rand_start < RANDOM_BYTES) begin
            idle_en = !(n_images == 2 || n_images == 3);
            random_image();
            n_images++;
        end
        idle_en = 1'b1;

        settle();
        repeat (4) @(posedge aclk);
        if (seg_sb.expected_segs.size() != 0)
            seg_sb.report($sformatf("%0d segments never arrived", seg_sb.expected_segs.size()));

        $display("Run covered %0d live stream bytes over %0d random images plus directed cases.",
                 seg_sb.n_live, n_images);
        $display("Segments checked: %0d (%0d end markers, %0d in RLE4 mode), mismatches: %0d.",
                 seg_sb.n_checked, seg_sb.n_markers, seg_sb.n_rle4, seg_sb.n_errors);
        if (seg_sb.n_errors == 0) begin
            $display("** bmp_rle_decoder_top: PASSED **");
        end else begin
            $display("** bmp_rle_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule
